@@ src/sidt_pkg.sv @@
// Package for the sorted identifier table: sizes, sequencer states and the result record.
// Used by every module of the block but sidt_ram; depends on nothing.
`timescale 1ns / 1ps

package sidt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ID_WIDTH    = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_SHIFT,
        ST_PLACE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              present;
        logic              full;
    } result_t;

endpackage

@@ src/sidt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module sidt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/sidt_engine.sv @@
// Search and insert sequencer: binary search over the table RAM, then, on an insert, shift and place.
// Depends on sidt_pkg and sidt_ram.
`timescale 1ns / 1ps

module sidt_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sidt_pkg::ID_WIDTH-1:0] key,
    output logic                         idle,
    output logic                         done,
    input  logic                         take,
    output sidt_pkg::result_t            result
);

    sidt_pkg::state_t state_reg, state_next;

    logic [sidt_pkg::ID_WIDTH-1:0] key_reg, key_next;
    logic [sidt_pkg::CNT_W-1:0]    lo_reg, lo_next;
    logic [sidt_pkg::CNT_W-1:0]    hi_reg, hi_next;
    logic [sidt_pkg::CNT_W-1:0]    mid_reg, mid_next;
    logic [sidt_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [sidt_pkg::ADDR_W-1:0]   src_reg, src_next;
    logic                          hit_reg, hit_next;
    logic                          full_reg, full_next;

    logic [sidt_pkg::CNT_W:0]      mid_sum;
    logic [sidt_pkg::CNT_W-1:0]    mid;
    logic [sidt_pkg::CNT_W-1:0]    cnt_m1;
    logic                          is_full;

    logic                          we;
    logic [sidt_pkg::ADDR_W-1:0]   waddr;
    logic [sidt_pkg::ID_WIDTH-1:0] wdata;
    logic                          re;
    logic [sidt_pkg::ADDR_W-1:0]   raddr;
    logic [sidt_pkg::ID_WIDTH-1:0] rdata;

    sidt_ram #(
        .WIDTH(sidt_pkg::ID_WIDTH),
        .DEPTH(sidt_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[sidt_pkg::CNT_W:1];
    assign cnt_m1  = count_reg - sidt_pkg::CNT_W'(1);
    assign is_full = (count_reg == sidt_pkg::CNT_W'(sidt_pkg::TABLE_DEPTH));

    assign idle           = (state_reg == sidt_pkg::ST_IDLE);
    assign done           = (state_reg == sidt_pkg::ST_DONE);
    assign result.slot    = sidt_pkg::SLOT_W'(lo_reg);
    assign result.present = hit_reg;
    assign result.full    = full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sidt_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        src_reg  <= src_next;
        hit_reg  <= hit_next;
        full_reg <= full_next;
    end

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        count_next = count_reg;
        src_next   = src_reg;
        hit_next   = hit_reg;
        full_next  = full_reg;
        we         = 1'b0;
        waddr      = src_reg + sidt_pkg::ADDR_W'(1);
        wdata      = rdata;
        re         = 1'b0;
        raddr      = mid[sidt_pkg::ADDR_W-1:0];

        case (state_reg)
            sidt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    hit_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = sidt_pkg::ST_PROBE;
                end
            end
            sidt_pkg::ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    re         = 1'b1;
                    raddr      = mid[sidt_pkg::ADDR_W-1:0];
                    mid_next   = mid;
                    state_next = sidt_pkg::ST_COMPARE;
                end
                else if (hit_reg || is_full)
                begin
                    full_next  = !hit_reg && is_full;
                    state_next = sidt_pkg::ST_DONE;
                end
                else if (lo_reg == count_reg)
                begin
                    state_next = sidt_pkg::ST_PLACE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = cnt_m1[sidt_pkg::ADDR_W-1:0];
                    src_next   = cnt_m1[sidt_pkg::ADDR_W-1:0];
                    state_next = sidt_pkg::ST_SHIFT;
                end
            end
            sidt_pkg::ST_COMPARE:
            begin
                if (rdata < key_reg)
                begin
                    lo_next = mid_reg + sidt_pkg::CNT_W'(1);
                end
                else
                begin
                    hi_next  = mid_reg;
                    hit_next = (rdata == key_reg);
                end
                state_next = sidt_pkg::ST_PROBE;
            end
            sidt_pkg::ST_SHIFT:
            begin
                we    = 1'b1;
                waddr = src_reg + sidt_pkg::ADDR_W'(1);
                wdata = rdata;
                if (sidt_pkg::CNT_W'(src_reg) == lo_reg)
                begin
                    state_next = sidt_pkg::ST_PLACE;
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = src_reg - sidt_pkg::ADDR_W'(1);
                    src_next = src_reg - sidt_pkg::ADDR_W'(1);
                end
            end
            sidt_pkg::ST_PLACE:
            begin
                we         = 1'b1;
                waddr      = lo_reg[sidt_pkg::ADDR_W-1:0];
                wdata      = key_reg;
                count_next = count_reg + sidt_pkg::CNT_W'(1);
                state_next = sidt_pkg::ST_DONE;
            end
            sidt_pkg::ST_DONE:
            begin
                if (take)
                begin
                    state_next = sidt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sidt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/sorted_id_table_lookup_insert_top.sv @@
// Top level of the sorted identifier table: request handshake and result register.
// Depends on sidt_pkg and sidt_engine.
//
//   channel   signals                                        dir
//   request   key_valid, key_stall, key_id                    in
//   result    result_valid, result_stall, slot_index,         out
//             was_present, table_full
//
// One request runs up to 7 search probes over 64 entries, each a table read and a compare;
// on an insert each entry above the slot then moves up one place and the new identifier
// is written into the slot; the result is then handed to the output register.
// The search and the shift both go through the single table RAM, with one write and one read port.
// Reset empties the table through the entry count; no clearing pass is needed.
// A stalled result holds in the output register while the next request is taken.
`timescale 1ns / 1ps

module sorted_id_table_lookup_insert_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          key_valid,
    output logic                          key_stall,
    input  logic [sidt_pkg::ID_WIDTH-1:0] key_id,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [sidt_pkg::SLOT_W-1:0]   slot_index,
    output logic                          was_present,
    output logic                          table_full
);

    logic              eng_idle;
    logic              eng_done;
    logic              eng_take;
    sidt_pkg::result_t eng_result;

    logic              out_valid_reg, out_valid_next;
    sidt_pkg::result_t out_reg, out_next;

    sidt_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (key_valid && eng_idle),
        .key   (key_id),
        .idle  (eng_idle),
        .done  (eng_done),
        .take  (eng_take),
        .result(eng_result)
    );

    assign key_stall = !eng_idle;
    assign eng_take  = eng_done && (!out_valid_reg || !result_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (eng_take)
        begin
            out_valid_next = 1'b1;
            out_next       = eng_result;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign slot_index   = out_reg.slot;
    assign was_present  = out_reg.present;
    assign table_full   = out_reg.full;

endmodule

@@ src/sidt_checker.sv @@
// Port-level checks for the sorted identifier table, bound to the top level.
// Depends on sidt_pkg and sorted_id_table_lookup_insert_top.
`timescale 1ns / 1ps

module sidt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          key_valid,
    input logic                          key_stall,
    input logic [sidt_pkg::ID_WIDTH-1:0] key_id,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [sidt_pkg::SLOT_W-1:0]   slot_index,
    input logic                          was_present,
    input logic                          table_full
);

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall |=> key_stall)
        else $error("request accepted without going busy");

    a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(was_present && table_full))
        else $error("result flags both hit and full");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (slot_index <= sidt_pkg::SLOT_W'(sidt_pkg::TABLE_DEPTH)))
        else $error("slot index beyond table depth");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(slot_index)
            && $stable(was_present) && $stable(table_full))
        else $error("stalled result changed");

endmodule

bind sorted_id_table_lookup_insert_top sidt_checker u_sidt_checker (.*);

@@ dv/sidt_table_checker.sv @@
// Checker for the sorted identifier table: watches both channels and predicts results.
// Keeps its own sorted copy of the table; depends on sidt_pkg.
`timescale 1ns / 1ps

module sidt_table_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          key_valid,
    input  logic                          key_stall,
    input  logic [sidt_pkg::ID_WIDTH-1:0] key_id,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [sidt_pkg::SLOT_W-1:0]   slot_index,
    input  logic                          was_present,
    input  logic                          table_full,
    output int                            error_count,
    output int                            awaiting
);

    logic [sidt_pkg::ID_WIDTH-1:0] sorted_ids [sidt_pkg::TABLE_DEPTH];
    int                            entry_total;
    sidt_pkg::result_t             slot_expect [$];

    function automatic sidt_pkg::result_t lookup_and_insert(
        input logic [sidt_pkg::ID_WIDTH-1:0] id
    );
        sidt_pkg::result_t r;
        int                pos;
        pos = 0;
        for (int i = 0; i < entry_total; i++)
            if (sorted_ids[i] < id)
                pos++;
        r.slot    = pos[sidt_pkg::SLOT_W-1:0];
        r.present = (pos < entry_total) && (sorted_ids[pos] == id);
        r.full    = 1'b0;
        if (!r.present)
        begin
            if (entry_total >= sidt_pkg::TABLE_DEPTH)
            begin
                r.full = 1'b1;
            end
            else
            begin
                for (int i = entry_total; i > pos; i--)
                    sorted_ids[i] = sorted_ids[i - 1];
                sorted_ids[pos] = id;
                entry_total++;
            end
        end
        return r;
    endfunction

    initial
    begin
        error_count = 0;
        awaiting    = 0;
        entry_total = 0;
        for (int i = 0; i < sidt_pkg::TABLE_DEPTH; i++)
            sorted_ids[i] = '0;
    end

    always @(posedge clk)
    begin
        sidt_pkg::result_t want;
        if (rst_n)
        begin
            if (key_valid && !key_stall)
                slot_expect = {slot_expect, lookup_and_insert(key_id)};
            if (result_valid && !result_stall)
            begin
                if (slot_expect.size() == 0)
                begin
                    $error("result with no request waiting: slot_index %0d", slot_index);
                    error_count++;
                end
                else
                begin
                    want = slot_expect.pop_front();
                    if (slot_index !== want.slot)
                    begin
                        $error("slot_index expected %0d actual %0d", want.slot, slot_index);
                        error_count++;
                    end
                    if (was_present !== want.present)
                    begin
                        $error("was_present expected %0d actual %0d",
                               want.present, was_present);
                        error_count++;
                    end
                    if (table_full !== want.full)
                    begin
                        $error("table_full expected %0d actual %0d", want.full, table_full);
                        error_count++;
                    end
                end
            end
            awaiting = slot_expect.size();
        end
    end

endmodule

@@ dv/sorted_id_table_lookup_insert_top_tb.sv @@
// Testbench top for the sorted identifier table: clock, reset, requests and verdict.
// Depends on sidt_pkg, sorted_id_table_lookup_insert_top and sidt_table_checker.
`timescale 1ns / 1ps

module sorted_id_table_lookup_insert_top_tb;

    localparam int REQUEST_TOTAL = 750;
    localparam int CYCLE_LIMIT   = 500000;

    logic                          clk;
    logic                          rst_n;
    logic                          key_valid;
    logic                          key_stall;
    logic [sidt_pkg::ID_WIDTH-1:0] key_id;
    logic                          result_valid;
    logic                          result_stall;
    logic [sidt_pkg::SLOT_W-1:0]   slot_index;
    logic                          was_present;
    logic                          table_full;
    int                            error_count;
    int                            awaiting;
    int                            cycle_count;
    int                            sent;
    logic [sidt_pkg::ID_WIDTH-1:0] stored_ids [$];

    sorted_id_table_lookup_insert_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_id       (key_id),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .slot_index   (slot_index),
        .was_present  (was_present),
        .table_full   (table_full)
    );

    sidt_table_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_id       (key_id),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .slot_index   (slot_index),
        .was_present  (was_present),
        .table_full   (table_full),
        .error_count  (error_count),
        .awaiting     (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit is_stored(input logic [sidt_pkg::ID_WIDTH-1:0] k);
        foreach (stored_ids[i])
            if (stored_ids[i] == k)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [sidt_pkg::ID_WIDTH-1:0] pick_stored();
        return stored_ids[$urandom_range(0, stored_ids.size() - 1)];
    endfunction

    task automatic offer_key(input logic [sidt_pkg::ID_WIDTH-1:0] k, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 99) < 16)
        begin
            key_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        key_valid <= 1'b1;
        key_id    <= k;
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
        if (!is_stored(k) && stored_ids.size() < sidt_pkg::TABLE_DEPTH)
            stored_ids = {stored_ids, k};
        sent++;
    endtask

    // receiver: long hold early, a quiet stretch later, random stalls otherwise
    initial
    begin
        int rcv_cycle;
        rcv_cycle = 0;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rcv_cycle++;
            if (rcv_cycle >= 400 && rcv_cycle < 700)
                result_stall <= 1'b1;
            else if (rcv_cycle >= 3000 && rcv_cycle < 9000)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(0, 99) < 16);
        end
    end

    initial
    begin
        logic [sidt_pkg::ID_WIDTH-1:0] k;
        int                            pick;
        cycle_count = 0;
        sent        = 0;
        rst_n     <= 1'b0;
        key_valid <= 1'b0;
        key_id    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, hit, insert at front, at end and in the middle
        offer_key(32'd5, 1'b1);
        offer_key(32'd5, 1'b1);
        offer_key(32'd3, 1'b1);
        offer_key(32'd9, 1'b1);
        offer_key(32'd7, 1'b1);
        offer_key(32'd3, 1'b1);
        offer_key(32'd9, 1'b1);

        // fill: mostly hits, keep 0 and all-ones out of the table
        while (stored_ids.size() < sidt_pkg::TABLE_DEPTH)
        begin
            if ($urandom_range(0, 99) < 30)
                k = $urandom_range(1, 32'hFFFF_FFFE);
            else
                k = pick_stored();
            offer_key(k, 1'b1);
        end

        // full table: below all, above all, hits at both ends and in the middle, and the key just above it
        stored_ids.sort();
        offer_key(32'h0000_0000, 1'b1);
        offer_key(32'hFFFF_FFFF, 1'b1);
        offer_key(stored_ids[0], 1'b1);
        offer_key(stored_ids[$], 1'b1);
        offer_key(stored_ids[32], 1'b1);
        offer_key(stored_ids[32] + 1, 1'b1);

        // hold until every result is back
        key_valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
        @(posedge clk);

        while (sent < REQUEST_TOTAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                k = pick_stored();
            else if (pick < 60)
                k = pick_stored() + (($urandom_range(0, 1) == 1) ? 32'd1 : 32'hFFFF_FFFF);
            else
                k = $urandom();
            offer_key(k, !(sent >= 400 && sent < 520));
        end

        key_valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
